// ===== rtl/hvt_pkg.sv =====
// ---------------------------------------------------------------------------
// hvt_pkg
// Shared constants and register index codes for the vertex transform.
// ---------------------------------------------------------------------------
package hvt_pkg;

  localparam int XW         = 32;  // coordinate and matrix entry width
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_COLS01 = 4'd0,
    REG_ROW0_COLS23 = 4'd1,
    REG_ROW1_COLS01 = 4'd2,
    REG_ROW1_COLS23 = 4'd3,
    REG_ROW2_COLS01 = 4'd4,
    REG_ROW2_COLS23 = 4'd5,
    REG_ROW3_COLS01 = 4'd6,
    REG_ROW3_COLS23 = 4'd7
  } cfg_reg_t;

endpackage

// ===== rtl/homogeneous_vertex_transform_top.sv =====
// ---------------------------------------------------------------------------
// homogeneous_vertex_transform_top
// Row vector (x,y,z,w) times a 4x4 fixed point matrix, then perspective
// divide of x, y, z by the transformed w, skipped when w is one or zero.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   in      | in_valid in_stall in_x..in_w       | sink
//   out     | out_valid out_stall out_x..out_w,  | source
//           | out_divided out_saturated          |
//   cfg     | cfg_we cfg_index cfg_data          | sink
//
// One beat per cycle while in_stall is low. Stages in order: multiply,
// pair add, column sum, abs, 32 + FRAC_BITS restoring divide steps (one
// quotient bit each, three lanes), output register.
// rst_n is synchronous and clears all valid bits; matrix resets to identity.
// A stall with a full output register parks one beat in a skid register;
// in_stall is high only while that skid register is occupied.
// ---------------------------------------------------------------------------
module homogeneous_vertex_transform_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [hvt_pkg::XW-1:0]     in_x,
  input  logic signed [hvt_pkg::XW-1:0]     in_y,
  input  logic signed [hvt_pkg::XW-1:0]     in_z,
  input  logic signed [hvt_pkg::XW-1:0]     in_w,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hvt_pkg::XW-1:0]     out_x,
  output logic signed [hvt_pkg::XW-1:0]     out_y,
  output logic signed [hvt_pkg::XW-1:0]     out_z,
  output logic signed [hvt_pkg::XW-1:0]     out_w,
  output logic                              out_divided,
  output logic                              out_saturated,
  input  logic                              cfg_we,
  input  logic [hvt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hvt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int W  = hvt_pkg::XW;
  localparam int QB = W + FRAC_BITS;  // quotient bits
  localparam logic signed [W-1:0] ONE  = W'(1) << FRAC_BITS;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  // ---------------- matrix registers ----------------
  logic signed [W-1:0] m_r [4][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          m_r[i][j] <= (i == j) ? ONE : '0;
        end
      end
    end else if (cfg_we) begin
      case (hvt_pkg::cfg_reg_t'(cfg_index))
        hvt_pkg::REG_ROW0_COLS01: begin m_r[0][0] <= cfg_data[31:0]; m_r[0][1] <= cfg_data[63:32]; end
        hvt_pkg::REG_ROW0_COLS23: begin m_r[0][2] <= cfg_data[31:0]; m_r[0][3] <= cfg_data[63:32]; end
        hvt_pkg::REG_ROW1_COLS01: begin m_r[1][0] <= cfg_data[31:0]; m_r[1][1] <= cfg_data[63:32]; end
        hvt_pkg::REG_ROW1_COLS23: begin m_r[1][2] <= cfg_data[31:0]; m_r[1][3] <= cfg_data[63:32]; end
        hvt_pkg::REG_ROW2_COLS01: begin m_r[2][0] <= cfg_data[31:0]; m_r[2][1] <= cfg_data[63:32]; end
        hvt_pkg::REG_ROW2_COLS23: begin m_r[2][2] <= cfg_data[31:0]; m_r[2][3] <= cfg_data[63:32]; end
        hvt_pkg::REG_ROW3_COLS01: begin m_r[3][0] <= cfg_data[31:0]; m_r[3][1] <= cfg_data[63:32]; end
        hvt_pkg::REG_ROW3_COLS23: begin m_r[3][2] <= cfg_data[31:0]; m_r[3][3] <= cfg_data[63:32]; end
        default: ;  // index beyond the list: ignored
      endcase
    end
  end

  // ---------------- pipeline enable ----------------
  logic en;
  logic skid_v_r;
  assign en       = !skid_v_r;
  assign in_stall = !en;

  logic signed [W-1:0] pin [4];
  assign pin[0] = in_x;
  assign pin[1] = in_y;
  assign pin[2] = in_z;
  assign pin[3] = in_w;

  // ---------------- stage 0: products ----------------
  logic                  v0_r;
  logic signed [2*W-1:0] prod_r [4][4];

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_r[i][j] <= pin[i] * m_r[i][j];
        end
      end
    end
  end

  // ---------------- stage 1: pair sums ----------------
  logic                  v1_r;
  logic signed [2*W:0]   pa_r [4];
  logic signed [2*W:0]   pb_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        pa_r[j] <= (2*W+1)'(prod_r[0][j]) + (2*W+1)'(prod_r[1][j]);
        pb_r[j] <= (2*W+1)'(prod_r[2][j]) + (2*W+1)'(prod_r[3][j]);
      end
    end
  end

  // ---------------- stage 2: column sum, floor shift, saturate ----------------
  logic                  v2_r;
  logic signed [W-1:0]   t_r [4];
  logic                  sat2_r;
  logic signed [2*W+1:0] tot   [4];
  logic signed [2*W+1:0] shf   [4];
  logic signed [W-1:0]   t_nxt [4];
  logic                  sat2_nxt;

  always_comb begin
    sat2_nxt = 1'b0;
    for (int j = 0; j < 4; j++) begin
      tot[j] = (2*W+2)'(pa_r[j]) + (2*W+2)'(pb_r[j]);
      shf[j] = tot[j] >>> FRAC_BITS;
      if (!shf[j][2*W+1] && (shf[j][2*W:W-1] != '0)) begin
        t_nxt[j] = SMAX;
        sat2_nxt = 1'b1;
      end else if (shf[j][2*W+1] && (shf[j][2*W:W-1] != '1)) begin
        t_nxt[j] = SMIN;
        sat2_nxt = 1'b1;
      end else begin
        t_nxt[j] = shf[j][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= t_nxt;
      sat2_r <= sat2_nxt;
    end
  end

  // ---------------- stage 3 + divide steps ----------------
  // index 0 holds magnitudes and signs; index k holds state after k steps.
  logic                dv_r   [QB+1];
  logic [W-1:0]        rem_r  [QB+1][3];
  logic [QB-1:0]       nq_r   [QB+1][3];  // numerator shifts out, quotient in
  logic                neg_r  [QB+1][3];
  logic signed [W-1:0] c_r    [QB+1][3];
  logic [W-1:0]        den_r  [QB+1];
  logic signed [W-1:0] w_r    [QB+1];
  logic                sat_r  [QB+1];

  logic [W-1:0] absc [3];
  logic [W-1:0] absw;

  always_comb begin
    absw = t_r[3][W-1] ? W'(-t_r[3]) : W'(t_r[3]);
    for (int l = 0; l < 3; l++) begin
      absc[l] = t_r[l][W-1] ? W'(-t_r[l]) : W'(t_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (en) dv_r[0] <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l] <= '0;
        nq_r[0][l]  <= QB'(absc[l]) << FRAC_BITS;
        neg_r[0][l] <= t_r[l][W-1] ^ t_r[3][W-1];
        c_r[0][l]   <= t_r[l];
      end
      den_r[0] <= absw;
      w_r[0]   <= t_r[3];
      sat_r[0] <= sat2_r;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [W+1:0] diff [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        diff[l] = {1'b0, rem_r[k-1][l], nq_r[k-1][l][QB-1]} - {2'b00, den_r[k-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k] <= 1'b0;
      else if (en) dv_r[k] <= dv_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          if (!diff[l][W+1]) begin
            rem_r[k][l] <= diff[l][W-1:0];
            nq_r[k][l]  <= {nq_r[k-1][l][QB-2:0], 1'b1};
          end else begin
            rem_r[k][l] <= {rem_r[k-1][l][W-2:0], nq_r[k-1][l][QB-1]};
            nq_r[k][l]  <= {nq_r[k-1][l][QB-2:0], 1'b0};
          end
          neg_r[k][l] <= neg_r[k-1][l];
          c_r[k][l]   <= c_r[k-1][l];
        end
        den_r[k] <= den_r[k-1];
        w_r[k]   <= w_r[k-1];
        sat_r[k] <= sat_r[k-1];
      end
    end
  end

  // ---------------- final select ----------------
  localparam logic [QB-1:0] QPOS = QB'(SMAX);
  localparam logic [QB-1:0] QNEG = QB'({1'b1, {(W-1){1'b0}}});

  logic                do_div;
  logic                fsat;
  logic signed [W-1:0] res [3];
  logic [QB-1:0]       q;

  always_comb begin
    do_div = (w_r[QB] != ONE) && (w_r[QB] != '0);
    fsat   = sat_r[QB];
    q      = '0;
    for (int l = 0; l < 3; l++) begin
      q = nq_r[QB][l];
      if (!do_div) begin
        res[l] = c_r[QB][l];
      end else if (!neg_r[QB][l] && (q > QPOS)) begin
        res[l] = SMAX;
        fsat   = 1'b1;
      end else if (neg_r[QB][l] && (q > QNEG)) begin
        res[l] = SMIN;
        fsat   = 1'b1;
      end else begin
        res[l] = neg_r[QB][l] ? W'(-q[W-1:0]) : W'(q[W-1:0]);
      end
    end
  end

  // ---------------- output register and skid ----------------
  logic                out_v_r;
  logic signed [W-1:0] ox_r, oy_r, oz_r, ow_r;
  logic                odiv_r, osat_r;
  logic signed [W-1:0] sx_r, sy_r, sz_r, sw_r;
  logic                sdiv_r, ssat_r;
  logic                slot_free;
  logic                p_v;

  assign slot_free = !out_v_r || !out_stall;
  assign p_v       = en && dv_r[QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (slot_free) begin
      out_v_r  <= skid_v_r || p_v;
      skid_v_r <= 1'b0;
    end else if (p_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (skid_v_r) begin
        ox_r <= sx_r; oy_r <= sy_r; oz_r <= sz_r; ow_r <= sw_r;
        odiv_r <= sdiv_r; osat_r <= ssat_r;
      end else begin
        ox_r <= res[0]; oy_r <= res[1]; oz_r <= res[2]; ow_r <= w_r[QB];
        odiv_r <= do_div; osat_r <= fsat;
      end
    end else if (p_v) begin
      sx_r <= res[0]; sy_r <= res[1]; sz_r <= res[2]; sw_r <= w_r[QB];
      sdiv_r <= do_div; ssat_r <= fsat;
    end
  end

  assign out_valid     = out_v_r;
  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_z         = oz_r;
  assign out_w         = ow_r;
  assign out_divided   = odiv_r;
  assign out_saturated = osat_r;

endmodule

// ===== rtl/hvt_checker.sv =====
// ---------------------------------------------------------------------------
// hvt_checker
// Port-level checks on the vertex transform output channel.
// ---------------------------------------------------------------------------
module hvt_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [hvt_pkg::XW-1:0] out_x,
  input logic signed [hvt_pkg::XW-1:0] out_w,
  input logic                          out_divided
);

  localparam logic signed [hvt_pkg::XW-1:0] ONE = hvt_pkg::XW'(1) << FRAC_BITS;

  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x))
    else $error("stalled beat dropped or changed");

  a_no_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_w == ONE || out_w == '0) |-> !out_divided)
    else $error("divide flagged for w of one or zero");

  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_w != ONE && out_w != '0 |-> out_divided)
    else $error("divide missing");

endmodule

bind homogeneous_vertex_transform_top hvt_checker #(.FRAC_BITS(FRAC_BITS)) u_hvt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_x       (out_x),
  .out_w       (out_w),
  .out_divided (out_divided)
);
